>>> sv/multi_axis_dda_step_generator_macros.svh
// assertion macros used by the step generator top level
`ifndef MULTI_AXIS_DDA_STEP_GENERATOR_MACROS_SVH
`define MULTI_AXIS_DDA_STEP_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define MDDA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdda assertion failed");
// next-cycle implication, disabled while in reset
`define MDDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdda assertion failed");
`else
`define MDDA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MDDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/mdda_pkg.sv
// types and constants shared by the dda step generator
package mdda_pkg;

  localparam int NUM_PORT_AXES = 6;
  localparam int TICKS_W       = 16;
  localparam int INC_W         = 33;
  localparam int ACC_W         = 40;
  localparam int SCALED_W      = 34;
  localparam int FACTOR_W      = 8;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_LINE  = 2'd1,
    FUNC_DWELL = 2'd2,
    FUNC_NULL  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ZERO_LEN = 2'd2
  } status_t;

  localparam logic [1:0] CFG_POLARITY     = 2'd0;
  localparam logic [1:0] CFG_PRESENT      = 2'd1;
  localparam logic [1:0] CFG_RESET_FACTOR = 2'd2;

  // per-lane controls, all already qualified by the pipeline advance
  typedef struct packed {
    logic tick_en;    // running line takes one tick
    logic load_line;  // staged line becomes the running segment
    logic acc_reset;  // anti-stall accumulator reset on load
    logic seg_end;    // running segment finished
    logic stage_wr;   // new line written into the stage
  } lane_ctl_t;

endpackage

>>> sv/multi_axis_dda_step_generator.sv
// top level of the six-axis dda step pulse generator
//
// channel | dir | handshake             | payload
// in_     | in  | in_tvalid / in_tready | tuser func, tdata ticks, increments, neg mask
// out_    | out | out_tvalid/out_tready | tdata steps, dir, enables, busy; tlast end; tuser status
// cfg_    | in  | cfg_valid / cfg_ready | cfg_index register, cfg_data value
//
// one item per cycle sustained while out_tready stays high
// the input register feeds one pass of lane adds and control into the result register
// a stalled result register holds the input register, which then drops in_tready
// rst_n is synchronous, active low; cfg_ready is always high
`include "multi_axis_dda_step_generator_macros.svh"
module multi_axis_dda_step_generator
  import mdda_pkg::*;
#(
  parameter int AXES      = 6,
  parameter int SUBSTEPS  = 100000,
  parameter int TICK_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] seg_ticks, [48:16] inc_axis0, [81:49] inc_axis1, [114:82] inc_axis2,
  // [147:115] inc_axis3, [180:148] inc_axis4, [213:181] inc_axis5, [219:214] neg_mask
  input  logic [223:0] in_tdata,
  input  logic [1:0]   in_tuser,   // [1:0] func
  output logic         out_tvalid,
  input  logic         out_tready,
  // [5:0] step_mask, [11:6] dir_out, [17:12] energized, [18] busy_res
  output logic [23:0]  out_tdata,
  output logic [1:0]   out_tuser,  // [1:0] status
  output logic         out_tlast,  // segment_end
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  localparam int NAX = (AXES < NUM_PORT_AXES) ? AXES : NUM_PORT_AXES;
  localparam int TW  = (TICK_BITS < TICKS_W) ? TICK_BITS : TICKS_W;
  localparam logic [NUM_PORT_AXES-1:0] AX_MASK = NUM_PORT_AXES'((64'd1 << NAX) - 64'd1);
  localparam logic [SCALED_W-1:0] SUBSTEPS_C = SCALED_W'(SUBSTEPS);

  // configuration registers
  logic [NUM_PORT_AXES-1:0] polarity_r, present_r;
  logic [FACTOR_W-1:0]      factor_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polarity_r <= '0;
      present_r  <= '1;
      factor_r   <= FACTOR_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLARITY:     polarity_r <= cfg_data[NUM_PORT_AXES-1:0];
        CFG_PRESENT:      present_r  <= cfg_data[NUM_PORT_AXES-1:0];
        CFG_RESET_FACTOR: factor_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                     s1_valid_r;
  func_t                    s1_func_r;
  logic [TICKS_W-1:0]       s1_ticks_r;
  logic [INC_W-1:0]         s1_inc_r [NUM_PORT_AXES];
  logic [NUM_PORT_AXES-1:0] s1_neg_r;
  logic                     advance;
  logic                     in_xfer;

  // result register
  logic                     out_valid_r;
  logic [NUM_PORT_AXES-1:0] out_step_r, out_dir_r, out_en_r;
  logic                     out_busy_r, out_end_r;
  status_t                  out_status_r;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r   <= func_t'(in_tuser);
      s1_ticks_r  <= in_tdata[15:0];
      s1_inc_r[0] <= in_tdata[48:16];
      s1_inc_r[1] <= in_tdata[81:49];
      s1_inc_r[2] <= in_tdata[114:82];
      s1_inc_r[3] <= in_tdata[147:115];
      s1_inc_r[4] <= in_tdata[180:148];
      s1_inc_r[5] <= in_tdata[213:181];
      s1_neg_r    <= in_tdata[219:214];
    end
  end

  // segment and staging state
  logic [TW-1:0]            down_count_r, down_count_nxt;
  logic [SCALED_W-1:0]      run_scaled_r, run_scaled_nxt;
  logic                     run_dwell_r, run_dwell_nxt;
  logic [NUM_PORT_AXES-1:0] dir_r, dir_nxt;
  logic [NUM_PORT_AXES-1:0] enable_r, enable_nxt;
  logic                     stage_valid_r, stage_valid_nxt;
  func_t                    stage_kind_r, stage_kind_nxt;
  logic [TW-1:0]            stage_ticks_r, stage_ticks_nxt;
  logic [SCALED_W-1:0]      stage_scaled_r, stage_scaled_nxt;
  logic [NUM_PORT_AXES-1:0] stage_dir_r, stage_dir_nxt;
  logic                     stage_flag_r, stage_flag_nxt;
  logic [TW-1:0]            prev_ticks_r, prev_ticks_nxt;

  // per-item control
  logic [TW-1:0]            ticks;
  logic [SCALED_W-1:0]      scaled_new;
  logic [TW+FACTOR_W-1:0]   ticks_times_factor;
  logic                     is_tick, tick_active, seg_end, zero_line, stage_wr, load;
  logic [TW-1:0]            dc_after;
  status_t                  status;
  lane_ctl_t                lane_ctl;
  logic [NUM_PORT_AXES-1:0] lane_step, lane_nz;
  logic [ACC_W-1:0]         acc_reset_val;

  assign ticks              = s1_ticks_r[TW-1:0];
  assign scaled_new         = SCALED_W'(ticks) * SUBSTEPS_C;
  assign ticks_times_factor = (TW + FACTOR_W)'(ticks) * (TW + FACTOR_W)'(factor_r);

  always_comb begin
    is_tick     = (s1_func_r == FUNC_TICK);
    tick_active = is_tick && (down_count_r != '0);
    seg_end     = tick_active && (down_count_r == TW'(1));
    dc_after    = tick_active ? (down_count_r - TW'(1)) : down_count_r;
    zero_line   = (s1_func_r == FUNC_LINE) && (ticks == '0);
    stage_wr    = !is_tick && !stage_valid_r && !zero_line;

    if (!is_tick && stage_valid_r) begin
      status = ST_FULL;
    end else if (zero_line) begin
      status = ST_ZERO_LEN;
    end else begin
      status = ST_OK;
    end

    // staging: a new entry is taken only while no entry is held
    stage_kind_nxt   = stage_kind_r;
    stage_ticks_nxt  = stage_ticks_r;
    stage_scaled_nxt = stage_scaled_r;
    stage_dir_nxt    = stage_dir_r;
    stage_flag_nxt   = stage_flag_r;
    prev_ticks_nxt   = prev_ticks_r;
    if (stage_wr) begin
      stage_kind_nxt = s1_func_r;
      if (s1_func_r == FUNC_LINE) begin
        stage_ticks_nxt  = ticks;
        stage_scaled_nxt = scaled_new;
        stage_dir_nxt    = (s1_neg_r ^ polarity_r) & AX_MASK;
        // anti-stall: new segment much shorter than the last one
        stage_flag_nxt   = ticks_times_factor < (TW + FACTOR_W)'(prev_ticks_r);
        prev_ticks_nxt   = ticks;
      end else if (s1_func_r == FUNC_DWELL) begin
        stage_ticks_nxt = ticks;
      end else begin
        stage_ticks_nxt = '0;
      end
    end
    stage_valid_nxt = stage_valid_r || stage_wr;

    // end of the running segment
    down_count_nxt = dc_after;
    run_scaled_nxt = run_scaled_r;
    run_dwell_nxt  = seg_end ? 1'b0 : run_dwell_r;
    enable_nxt     = seg_end ? '0 : enable_r;
    dir_nxt        = dir_r;

    // load the stage as soon as nothing runs
    load = (dc_after == '0) && stage_valid_nxt;
    lane_ctl.load_line = 1'b0;
    lane_ctl.acc_reset = 1'b0;
    if (load) begin
      stage_valid_nxt = 1'b0;
      case (stage_kind_nxt)
        FUNC_LINE: begin
          down_count_nxt     = stage_ticks_nxt;
          run_scaled_nxt     = stage_scaled_nxt;
          run_dwell_nxt      = 1'b0;
          lane_ctl.load_line = 1'b1;
          lane_ctl.acc_reset = stage_flag_nxt;
          dir_nxt            = (dir_r & ~lane_nz) | (stage_dir_nxt & lane_nz);
          enable_nxt         = enable_nxt | lane_nz;
        end
        FUNC_DWELL: begin
          down_count_nxt = stage_ticks_nxt;
          run_dwell_nxt  = 1'b1;
        end
        default: ;
      endcase
    end

    lane_ctl.tick_en   = tick_active && !run_dwell_r;
    lane_ctl.seg_end   = seg_end;
    lane_ctl.stage_wr  = stage_wr && (s1_func_r == FUNC_LINE);
    lane_ctl.load_line = lane_ctl.load_line && advance;
    lane_ctl.acc_reset = lane_ctl.acc_reset && advance;
    lane_ctl.tick_en   = lane_ctl.tick_en && advance;
    lane_ctl.seg_end   = lane_ctl.seg_end && advance;
    lane_ctl.stage_wr  = lane_ctl.stage_wr && advance;
  end

  // accumulator start value for the anti-stall reset: minus the tick count
  assign acc_reset_val = '0 - ACC_W'(stage_ticks_nxt);

  for (genvar g = 0; g < NUM_PORT_AXES; g++) begin : g_lane
    if (g < NAX) begin : g_on
      mdda_lane u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (lane_ctl),
        .present   (present_r[g]),
        .new_inc   (s1_inc_r[g]),
        .scaled    (run_scaled_r),
        .reset_val (acc_reset_val),
        .step      (lane_step[g]),
        .inc_nz    (lane_nz[g])
      );
    end else begin : g_off
      assign lane_step[g] = 1'b0;
      assign lane_nz[g]   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_count_r  <= '0;
      run_scaled_r  <= '0;
      run_dwell_r   <= 1'b0;
      dir_r         <= '0;
      enable_r      <= '0;
      stage_valid_r <= 1'b0;
      stage_kind_r  <= FUNC_TICK;
      stage_ticks_r <= '0;
      stage_flag_r  <= 1'b0;
      prev_ticks_r  <= '0;
    end else if (advance) begin
      down_count_r  <= down_count_nxt;
      run_scaled_r  <= run_scaled_nxt;
      run_dwell_r   <= run_dwell_nxt;
      dir_r         <= dir_nxt;
      enable_r      <= enable_nxt;
      stage_valid_r <= stage_valid_nxt;
      stage_kind_r  <= stage_kind_nxt;
      stage_ticks_r <= stage_ticks_nxt;
      stage_flag_r  <= stage_flag_nxt;
      prev_ticks_r  <= prev_ticks_nxt;
    end
  end

  // staged line data, only read after a line was staged
  always_ff @(posedge clk) begin
    if (advance) begin
      stage_scaled_r <= stage_scaled_nxt;
      stage_dir_r    <= stage_dir_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_step_r   <= lane_step;
      out_dir_r    <= dir_nxt;
      out_en_r     <= enable_nxt;
      out_busy_r   <= (down_count_nxt != '0);
      out_end_r    <= seg_end;
      out_status_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_busy_r, out_en_r, out_dir_r, out_step_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_end_r;

  // a full stage is always waiting behind a running segment
  `MDDA_ASSERT_IMPL(a_stage_behind_run, clk, rst_n, stage_valid_r, down_count_r != '0)
  // drivers are only powered while a line segment counts down
  `MDDA_ASSERT_IMPL(a_enable_only_running, clk, rst_n, enable_r != '0, down_count_r != '0)
  // a rejected staging transfer carries no step and no segment end
  `MDDA_ASSERT_IMPL(a_reject_quiet, clk, rst_n, out_valid_r && (out_status_r != ST_OK),
                    (out_step_r == '0) && !out_end_r)
  // a stalled input item stays in the input register
  `MDDA_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !advance, s1_valid_r)

endmodule

>>> sv/mdda_lane.sv
// one axis: phase accumulator, running and staged increments
module mdda_lane
  import mdda_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  lane_ctl_t           ctl,
  input  logic                present,
  input  logic [INC_W-1:0]    new_inc,
  input  logic [SCALED_W-1:0] scaled,
  input  logic [ACC_W-1:0]    reset_val,
  output logic                step,
  output logic                inc_nz
);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [INC_W-1:0] run_inc_r, run_inc_nxt;
  logic [INC_W-1:0] stage_inc_r, stage_inc_nxt;
  logic [INC_W-1:0] stage_eff;
  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] sat;
  logic [ACC_W-1:0] after_step;
  logic             pos;
  logic             tick_now;

  assign tick_now = ctl.tick_en & present;

  always_comb begin
    sum = {acc_r[ACC_W-1], acc_r} + {{(ACC_W + 1 - INC_W){1'b0}}, run_inc_r};
    // positive overflow clamps to the largest accumulator value
    if (!sum[ACC_W] && sum[ACC_W-1]) begin
      sat = {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      sat = sum[ACC_W-1:0];
    end
    pos = !sat[ACC_W-1] && (sat != '0);
    after_step = pos ? (sat - {{(ACC_W - SCALED_W){1'b0}}, scaled}) : sat;
  end

  assign step      = tick_now & pos;
  assign stage_eff = ctl.stage_wr ? new_inc : stage_inc_r;
  assign inc_nz    = |stage_eff;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.acc_reset) begin
      acc_nxt = reset_val;
    end else if (tick_now) begin
      acc_nxt = after_step;
    end
    run_inc_nxt = run_inc_r;
    if (ctl.load_line) begin
      run_inc_nxt = stage_eff;
    end else if (ctl.seg_end) begin
      run_inc_nxt = '0;
    end
    stage_inc_nxt = stage_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      run_inc_r <= '0;
    end else begin
      acc_r     <= acc_nxt;
      run_inc_r <= run_inc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_inc_r <= stage_inc_nxt;
  end

endmodule

>>> tb/sv/multi_axis_dda_step_generator_test.sv
// self-checking testbench for the six-axis dda step pulse generator
`timescale 1ns / 1ps

module multi_axis_dda_step_generator_test;
  import mdda_pkg::*;

  localparam int     SUBSTEP_COUNT = 100000;
  localparam longint ACC_TOP      = 64'sd549755813887;  // largest 40-bit signed sum
  localparam logic [1:0] CFG_SPARE = 2'd3;              // unmapped register index
  localparam logic [32:0] INC_MAX = 33'h1FFFFFFFF;

  // one input transfer: func travels on tuser, the rest packed into tdata
  typedef struct packed {
    func_t                     func;
    logic [5:0]                neg;
    logic [5:0][INC_W-1:0]     inc;
    logic [TICKS_W-1:0]        ticks;
  } dda_item_t;

  // one result transfer, split into its fields
  typedef struct packed {
    status_t    status;
    logic       seg_end;
    logic       busy;
    logic [5:0] energized;
    logic [5:0] dir;
    logic [5:0] steps;
  } dda_result_t;

  // directed row: the expectation is only typed in where it is obvious
  typedef struct {
    dda_item_t   it;
    bit          typed;
    dda_result_t want;
  } script_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [223:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [7:0]   cfg_data = '0;

  multi_axis_dda_step_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state, mirrors the block after reset
  // ---------------------------------------------------------------------------
  logic [5:0]              cfg_pol = 6'h00;
  logic [5:0]              cfg_present = 6'h3F;
  logic [FACTOR_W-1:0]     cfg_factor = 8'd2;

  logic signed [ACC_W-1:0] acc [NUM_PORT_AXES] = '{default: '0};
  logic [INC_W-1:0]        seg_inc [NUM_PORT_AXES] = '{default: '0};
  logic [TICKS_W-1:0]      ticks_left = '0;
  logic [SCALED_W-1:0]     ticks_scaled = '0;
  bit                      in_dwell = 1'b0;
  logic [5:0]              dir_pins = '0;
  logic [5:0]              drv_en = '0;
  // staging buffer
  bit                      hold_full = 1'b0;
  func_t                   hold_kind = FUNC_TICK;
  logic [TICKS_W-1:0]      hold_ticks = '0;
  logic [5:0][INC_W-1:0]   hold_inc = '0;
  logic [5:0]              hold_dir = '0;
  bit                      hold_rewind = 1'b0;
  logic [TICKS_W-1:0]      last_line_ticks = '0;

  dda_result_t pulse_q [$];   // expected results, oldest first
  bit          gaps_on = 1'b1;
  int          n_sent, n_results, n_errors, n_stepped, n_ends, n_rejects, n_settings;
  int          stall_left;
  bit          long_stall_done;

  // staged segment becomes the running one
  function automatic void load_held();
    int i;
    hold_full = 1'b0;
    if (hold_kind == FUNC_LINE) begin
      ticks_left   = hold_ticks;
      ticks_scaled = SCALED_W'(hold_ticks) * SCALED_W'(SUBSTEP_COUNT);
      in_dwell     = 1'b0;
      for (i = 0; i < NUM_PORT_AXES; i++) begin
        seg_inc[i] = hold_inc[i];
        // anti-stall: every accumulator restarts just below zero
        if (hold_rewind) acc[i] = -ACC_W'(hold_ticks);
        if (seg_inc[i] != '0) begin
          dir_pins[i] = hold_dir[i];
          drv_en[i]   = 1'b1;
        end
      end
    end else if (hold_kind == FUNC_DWELL) begin
      ticks_left = hold_ticks;
      in_dwell   = 1'b1;
    end
  endfunction

  // expected result of one input transfer; advances the predictor state
  function automatic dda_result_t predict_pulses(dda_item_t it);
    dda_result_t r;
    longint      s;
    int          i;
    r = '0;
    r.status = ST_OK;
    if (it.func == FUNC_TICK) begin
      if (ticks_left != 0) begin
        if (!in_dwell) begin
          for (i = 0; i < NUM_PORT_AXES; i++) begin
            if (cfg_present[i]) begin
              s = longint'(acc[i]) + longint'({31'b0, seg_inc[i]});
              if (s > ACC_TOP) s = ACC_TOP;
              if (s > 0) begin
                s -= longint'({30'b0, ticks_scaled});
                r.steps[i] = 1'b1;
              end
              acc[i] = s[ACC_W-1:0];
            end
          end
        end
        ticks_left--;
        if (ticks_left == 0) begin
          r.seg_end = 1'b1;
          drv_en    = '0;
          in_dwell  = 1'b0;
          for (i = 0; i < NUM_PORT_AXES; i++) seg_inc[i] = '0;
        end
      end
    end else if (hold_full) begin
      r.status = ST_FULL;
    end else if (it.func == FUNC_LINE) begin
      if (it.ticks == 0) begin
        r.status = ST_ZERO_LEN;
      end else begin
        hold_kind       = FUNC_LINE;
        hold_ticks      = it.ticks;
        hold_inc        = it.inc;
        hold_dir        = it.neg ^ cfg_pol;
        hold_rewind     = (32'(it.ticks) * 32'(cfg_factor)) < 32'(last_line_ticks);
        last_line_ticks = it.ticks;
        hold_full       = 1'b1;
      end
    end else begin
      hold_kind  = it.func;
      hold_ticks = (it.func == FUNC_DWELL) ? it.ticks : '0;
      hold_full  = 1'b1;
    end
    if (ticks_left == 0 && hold_full) load_held();
    r.dir       = dir_pins;
    r.energized = drv_en;
    r.busy      = (ticks_left != 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 25);
  endfunction

  function automatic script_row_t row(func_t f, logic [15:0] t, logic [32:0] inc,
                                      logic [5:0] neg);
    script_row_t sr;
    int i;
    sr.it       = '0;
    sr.it.func  = f;
    sr.it.ticks = t;
    sr.it.neg   = neg;
    for (i = 0; i < NUM_PORT_AXES; i++) sr.it.inc[i] = inc;
    sr.typed = 1'b0;
    sr.want  = '0;
    return sr;
  endfunction

  function automatic script_row_t known(script_row_t sr, logic [5:0] dir, logic [5:0] en,
                                        logic busy, status_t st);
    script_row_t k;
    k = sr;
    k.typed          = 1'b1;
    k.want           = '0;
    k.want.dir       = dir;
    k.want.energized = en;
    k.want.busy      = busy;
    k.want.status    = st;
    return k;
  endfunction

  // increments spread from zero through one step per tick up to the full field
  function automatic logic [32:0] rand_inc(logic [15:0] t);
    logic [63:0] span;
    span = 64'(t) * SUBSTEP_COUNT;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 33'($urandom_range(1, 1000));
      2, 3:    return 33'({$urandom, $urandom} % (span + 64'd1));
      4:       return {1'($urandom_range(0, 1)), 32'($urandom)};
      default: return INC_MAX;
    endcase
  endfunction

  // well-formed staging request with random content
  function automatic dda_item_t random_stage_item();
    dda_item_t it;
    int        r, i;
    it     = '0;
    it.neg = 6'($urandom);
    r      = $urandom_range(0, 99);
    if (r < 4) begin
      // long line with huge increments, drives accumulators into saturation
      it.func  = FUNC_LINE;
      it.ticks = 16'($urandom_range(70, 120));
      for (i = 0; i < NUM_PORT_AXES; i++)
        it.inc[i] = $urandom_range(0, 1) ? INC_MAX : rand_inc(it.ticks);
    end else if (r < 80) begin
      it.func  = FUNC_LINE;
      it.ticks = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(1, 12))
                                              : 16'($urandom_range(13, 150));
      for (i = 0; i < NUM_PORT_AXES; i++) it.inc[i] = rand_inc(it.ticks);
    end else if (r < 92) begin
      it.func  = FUNC_DWELL;
      it.ticks = 16'($urandom_range(0, 10));
    end else begin
      it.func  = FUNC_NULL;
      it.ticks = 16'($urandom);
    end
    return it;
  endfunction

  // one input transfer, expectation queued in order
  task automatic ship(input dda_item_t it, input dda_result_t want);
    int n;
    n = (gaps_on && $urandom_range(0, 99) < 25) ? gap_len() : 0;
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    pulse_q.push_back(want);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, it.neg, it.inc, it.ticks};
    in_tuser  <= it.func;
    do @(posedge clk); while (!in_tready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic ship_predicted(input dda_item_t it);
    ship(it, predict_pulses(it));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POLARITY:     cfg_pol = d[5:0];
      CFG_PRESENT:      cfg_present = d[5:0];
      CFG_RESET_FACTOR: cfg_factor = d;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // stop offering, wait for every result, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pulse_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] pol, input logic [7:0] present,
                                input logic [7:0] factor, input bit spare);
    drain();
    write_reg(CFG_POLARITY, pol);
    write_reg(CFG_PRESENT, present);
    write_reg(CFG_RESET_FACTOR, factor);
    if (spare) write_reg(CFG_SPARE, 8'($urandom));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic run_traffic(input int n_items);
    dda_item_t it;
    int        k, r, i;
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // noise: any func, full-range fields; long lines only where rejected
        it.func  = func_t'($urandom_range(0, 3));
        it.neg   = 6'($urandom);
        it.ticks = hold_full ? 16'($urandom) : 16'($urandom_range(0, 20));
        for (i = 0; i < NUM_PORT_AXES; i++)
          it.inc[i] = {1'($urandom_range(0, 1)), 32'($urandom)};
      end else if (!hold_full && (ticks_left == 0 || r < 35)) begin
        it = random_stage_item();
      end else begin
        it      = '0;
        it.func = FUNC_TICK;
      end
      ship_predicted(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!long_stall_done && n_results >= 700) begin
      // long enough that the pipeline fills and the input side stalls
      long_stall_done = 1'b1;
      stall_left      = 80;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 99) < 20) begin
      stall_left = gap_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      dda_result_t want;
      n_results++;
      if (out_tdata[5:0] != 0) n_stepped++;
      if (out_tlast) n_ends++;
      if (out_tuser != ST_OK) n_rejects++;
      if (pulse_q.size() == 0) begin
        $error("result transfer with no expected result pending");
        n_errors++;
      end else begin
        want = pulse_q.pop_front();
        check_field("step_mask",   8'(want.steps),     8'(out_tdata[5:0]));
        check_field("dir_out",     8'(want.dir),       8'(out_tdata[11:6]));
        check_field("energized",   8'(want.energized), 8'(out_tdata[17:12]));
        check_field("busy_res",    8'(want.busy),      8'(out_tdata[18]));
        check_field("segment_end", 8'(want.seg_end),   8'(out_tlast));
        check_field("status",      8'(want.status),    8'(out_tuser));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    script_row_t script [25];
    dda_result_t want;
    int          i;

    // directed walk, reset register values
    script[0]  = known(row(FUNC_TICK, 16'd0, 33'd0, 6'h00), 6'h00, 6'h00, 1'b0, ST_OK);
    script[1]  = known(row(FUNC_LINE, 16'd0, INC_MAX, 6'h3F), 6'h00, 6'h00, 1'b0, ST_ZERO_LEN);
    script[2]  = known(row(FUNC_NULL, 16'hFFFF, 33'd0, 6'h00), 6'h00, 6'h00, 1'b0, ST_OK);
    script[3]  = known(row(FUNC_DWELL, 16'd0, 33'd0, 6'h00), 6'h00, 6'h00, 1'b0, ST_OK);
    // full increments, all axes negative, loads at once
    script[4]  = known(row(FUNC_LINE, 16'd2, INC_MAX, 6'h3F), 6'h3F, 6'h3F, 1'b1, ST_OK);
    script[5]  = row(FUNC_LINE, 16'd1, 33'd0, 6'h00);
    script[6]  = known(row(FUNC_DWELL, 16'd5, 33'd0, 6'h00), 6'h3F, 6'h3F, 1'b1, ST_FULL);
    script[7]  = row(FUNC_TICK, 16'd0, 33'd0, 6'h00);
    script[8]  = row(FUNC_TICK, 16'd0, 33'd0, 6'h00);
    script[9]  = row(FUNC_TICK, 16'd0, 33'd0, 6'h00);
    script[10] = row(FUNC_LINE, 16'd4, 33'd1, 6'h2A);
    script[10].it.inc[1] = 33'd400000;
    script[10].it.inc[2] = 33'd0;
    script[10].it.inc[3] = 33'h100000000;
    script[10].it.inc[4] = 33'd200000;
    script[10].it.inc[5] = 33'd50000;
    // much shorter than the previous line: anti-stall reset on load
    script[11] = row(FUNC_LINE, 16'd1, 33'd5, 6'h15);
    script[12] = row(FUNC_NULL, 16'd0, 33'd0, 6'h00);
    for (i = 13; i <= 17; i++) script[i] = row(FUNC_TICK, 16'd0, 33'd0, 6'h00);
    script[18] = row(FUNC_DWELL, 16'd3, 33'd0, 6'h00);
    script[19] = row(FUNC_LINE, 16'd0, 33'd0, 6'h00);
    script[20] = row(FUNC_NULL, 16'd0, 33'd0, 6'h00);
    for (i = 21; i <= 24; i++) script[i] = row(FUNC_TICK, 16'd0, 33'd0, 6'h00);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    n_settings = 1;
    for (i = 0; i < 25; i++) begin
      want = predict_pulses(script[i].it);
      if (script[i].typed) want = script[i].want;
      ship(script[i].it, want);
    end

    // random phases, each under its own register setting
    gaps_on = 1'b1;
    apply_settings(8'h00, 8'h3F, 8'd2, 1'b0);
    run_traffic(305);
    gaps_on = 1'b0;
    apply_settings(8'h3F, 8'h00, 8'd255, 1'b0);
    run_traffic(305);
    gaps_on = 1'b1;
    apply_settings(8'h2A, 8'h15, 8'd1, 1'b0);
    run_traffic(305);
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)), 1'b1);
    run_traffic(305);
    gaps_on = 1'b0;
    apply_settings(8'h15, 8'h3F, 8'd0, 1'b0);
    run_traffic(305);
    gaps_on = 1'b1;
    apply_settings(8'hFF, 8'hFF, 8'd255, 1'b0);
    run_traffic(305);

    // longest line and dwell, left running at the end
    begin
      dda_item_t it;
      it       = '0;
      it.func  = FUNC_LINE;
      it.ticks = 16'hFFFF;
      it.neg   = 6'($urandom);
      for (i = 0; i < NUM_PORT_AXES; i++) it.inc[i] = INC_MAX;
      ship_predicted(it);
      it.func = FUNC_DWELL;
      ship_predicted(it);
      it.func = FUNC_TICK;
      for (i = 0; i < 20; i++) ship_predicted(it);
    end

    in_tvalid <= 1'b0;
    while (pulse_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("run: %0d input transfers under %0d register settings, %0d results checked",
             n_sent, n_settings, n_results);
    $display("run: %0d results with steps, %0d segment ends, %0d rejected staging requests",
             n_stepped, n_ends, n_rejects);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10000000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/mdda_pkg.sv
sv/mdda_lane.sv
sv/multi_axis_dda_step_generator.sv
tb/sv/multi_axis_dda_step_generator_test.sv
